### rtl/qoi_image_decoder_defines.svh
// Assertion macros shared by the QOI decoder RTL.
// Included by every file that carries concurrent assertions.
`ifndef QOI_IMAGE_DECODER_DEFINES_SVH
`define QOI_IMAGE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define QOI_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qoi_image_decoder: assertion failed");

// Next-cycle implication, disabled during reset
`define QOI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qoi_image_decoder: assertion failed");

`endif

### rtl/qoi_pkg.sv
// Shared types and constants for the QOI chunk-stream decoder.
// No dependencies; used by the burst stage and the top level.
package qoi_pkg;

  // Chunk opcodes and two-bit tags
  localparam logic [7:0] OP_RGB   = 8'hFE;
  localparam logic [7:0] OP_RGBA  = 8'hFF;
  localparam logic [1:0] TAG_INDEX = 2'd0;
  localparam logic [1:0] TAG_DIFF  = 2'd1;
  localparam logic [1:0] TAG_LUMA  = 2'd2;
  localparam logic [1:0] TAG_RUN   = 2'd3;

  // Colour index geometry
  localparam int INDEX_SLOTS = 64;
  localparam int SLOT_BITS   = $clog2(INDEX_SLOTS);

  // Opaque black, r g b a packed
  localparam logic [31:0] RGBA_RESET = 32'h0000_00FF;

  // Configuration register map
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_COUNT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_ENABLE  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_VALUE   = 2'd2;
  localparam int PCOUNT_BITS = 25;

  // Results caused by one byte: some pixels of one colour, then maybe an error
  typedef struct packed {
    logic [31:0] word;
    logic [5:0]  pixels;
    logic        done;
    logic        err;
  } qoi_burst_t;

  // Colour index slot: (r*3 + g*5 + b*7 + a*11) mod 64
  function automatic logic [SLOT_BITS-1:0] index_hash(input logic [31:0] rgba);
    logic [5:0] r, g, b, a, h;
    r = rgba[29:24];
    g = rgba[21:16];
    b = rgba[13:8];
    a = rgba[5:0];
    h = (r + {r[4:0], 1'b0})
      + (g + {g[3:0], 2'b0})
      + (b + {b[4:0], 1'b0} + {b[3:0], 2'b0})
      + (a + {a[4:0], 1'b0} + {a[2:0], 3'b0});
    return h;
  endfunction

endpackage

### rtl/qoi_if.sv
// Valid/ready channel interfaces of the QOI decoder.
// Chunk bytes in, pixel items out; no dependencies.
interface qoi_chunk_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source(output valid, data_byte, end_of_data, input ready);
  modport sink(input valid, data_byte, end_of_data, output ready);
endinterface

interface qoi_pixel_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_word;
  logic        image_done;
  logic        decode_error;
  logic        last;

  modport source(output valid, pixel_word, image_done, decode_error, last, input ready);
  modport sink(input valid, pixel_word, image_done, decode_error, last, output ready);
endinterface

### rtl/qoi_image_decoder.sv
// QOI chunk-stream decoder top level: byte register, op decode, colour index.
// Depends on qoi_pkg, qoi_if, qoi_ram, qoi_burst and the assertion macro header.
//
//   port    | dir | items                                       | accepted when
//   chunk   | in  | data_byte[7:0], end_of_data                  | valid & ready
//   pixel   | out | pixel_word[31:0], image_done, decode_error, last | valid & ready
//   cfg     | in  | cfg_index[1:0], cfg_data[31:0]               | cfg_write
//
// One byte per cycle unless stalled; byte and results are both registered.
// A byte with results waits in the byte register while the result stage plays
// out the previous byte's items still queued (up to 63).
// Synchronous reset; the colour index is cleared by its valid bits at once.
// Stalls on the pixel side reach chunk.ready through the result stage.
`include "qoi_image_decoder_defines.svh"

module qoi_image_decoder #(
  parameter int COUNT_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [qoi_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [31:0]                        cfg_data,
  qoi_chunk_if.sink                          chunk,
  qoi_pixel_if.source                        pixel
);

  localparam int PW = (COUNT_BITS < qoi_pkg::PCOUNT_BITS) ? COUNT_BITS + 1
                                                          : qoi_pkg::PCOUNT_BITS;
  localparam logic [32:0] LIMIT = 33'd1 << COUNT_BITS;
  localparam int SB = qoi_pkg::SLOT_BITS;

  // Configuration registers
  logic [qoi_pkg::PCOUNT_BITS-1:0] pixel_count;
  logic                            key_enable;
  logic [31:0]                     key_value;

  // Byte register
  logic       r1_valid;
  logic [7:0] r1_byte;
  logic       r1_eod;
  logic       r1_exec;
  logic       accept;

  // Per-image state
  logic [31:0]  rgba, rgba_next;
  logic [7:0]   op_pend, op_pend_next;
  logic [2:0]   needed, needed_next;
  logic [23:0]  gathered, gathered_next;
  logic [PW-1:0] emitted, emitted_next;
  logic         discard, discard_next;

  // Colour index
  logic [qoi_pkg::INDEX_SLOTS-1:0] idx_valid;
  logic [31:0]   ram_rdata;
  logic          ram_we;
  logic [SB-1:0] idx_waddr;
  logic          byp_hit;
  logic [31:0]   byp_data;
  logic [31:0]   lookup;

  // Decode results
  logic          emit;
  logic          img_clear;
  logic [5:0]    count;
  logic [5:0]    n_pix;
  logic          done;
  logic          err;
  logic          over;
  logic [PW-1:0] rem;
  logic [PW-1:0] target;
  logic [32:0]   target_wide;
  logic [7:0]    dg, cr, cg, cb;
  logic          has_items;
  logic          burst_free;
  logic          burst_load;
  qoi_pkg::qoi_burst_t desc;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= 25'd1;
      key_enable  <= 1'b0;
      key_value   <= 32'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        qoi_pkg::REG_PIXEL_COUNT: pixel_count <= cfg_data[qoi_pkg::PCOUNT_BITS-1:0];
        qoi_pkg::REG_KEY_ENABLE:  key_enable  <= cfg_data[0];
        qoi_pkg::REG_KEY_VALUE:   key_value   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Image size: zero counts as one, saturate at 2^COUNT_BITS
  always_comb begin
    target_wide = {8'd0, pixel_count};
    if (target_wide == 33'd0) begin
      target_wide = 33'd1;
    end
    if (target_wide > LIMIT) begin
      target_wide = LIMIT;
    end
    target = target_wide[PW-1:0];
  end

  // Input handshake
  assign chunk.ready = !r1_valid || r1_exec;
  assign accept      = chunk.valid && chunk.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else if (accept) begin
      r1_valid <= 1'b1;
    end else if (r1_exec) begin
      r1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r1_byte <= chunk.data_byte;
      r1_eod  <= chunk.end_of_data;
    end
  end

  // Colour index memory, read as the byte is taken
  qoi_ram #(
    .WIDTH(32),
    .DEPTH(qoi_pkg::INDEX_SLOTS)
  ) u_index (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx_waddr),
    .wdata(rgba_next),
    .re   (accept),
    .raddr(chunk.data_byte[SB-1:0]),
    .rdata(ram_rdata)
  );

  // Forward a write that lands on the edge of the read
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else if (accept) begin
      byp_hit <= ram_we && (idx_waddr == chunk.data_byte[SB-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byp_data <= rgba_next;
    end
  end

  assign lookup = !idx_valid[r1_byte[SB-1:0]] ? 32'd0
                : (byp_hit ? byp_data : ram_rdata);

  // Op decode and colour update
  always_comb begin
    rgba_next     = rgba;
    op_pend_next  = op_pend;
    needed_next   = needed;
    gathered_next = gathered;
    discard_next  = discard;
    emit          = 1'b0;
    img_clear     = 1'b0;
    count         = 6'd1;
    n_pix         = 6'd0;
    done          = 1'b0;
    err           = 1'b0;
    dg            = {2'b00, op_pend[5:0]} - 8'd32;
    cr            = rgba[31:24];
    cg            = rgba[23:16];
    cb            = rgba[15:8];

    if (discard) begin
      img_clear = r1_eod;
    end else begin
      if (needed != 3'd0) begin
        // Operand byte of a multi-byte op
        gathered_next = {gathered[15:0], r1_byte};
        needed_next   = needed - 3'd1;
        if (needed == 3'd1) begin
          emit         = 1'b1;
          op_pend_next = 8'd0;
          if (op_pend == qoi_pkg::OP_RGB) begin
            rgba_next = {gathered[15:0], r1_byte, rgba[7:0]};
          end else if (op_pend == qoi_pkg::OP_RGBA) begin
            rgba_next = {gathered, r1_byte};
          end else begin
            cr = rgba[31:24] + dg - 8'd8 + {4'd0, r1_byte[7:4]};
            cg = rgba[23:16] + dg;
            cb = rgba[15:8] + dg - 8'd8 + {4'd0, r1_byte[3:0]};
            rgba_next = {cr, cg, cb, rgba[7:0]};
          end
        end
      end else if (r1_byte == qoi_pkg::OP_RGB || r1_byte == qoi_pkg::OP_RGBA
                   || r1_byte[7:6] == qoi_pkg::TAG_LUMA) begin
        // Opcode that needs more bytes
        op_pend_next = r1_byte;
        if (r1_byte == qoi_pkg::OP_RGB) begin
          needed_next = 3'd3;
        end else if (r1_byte == qoi_pkg::OP_RGBA) begin
          needed_next = 3'd4;
        end else begin
          needed_next = 3'd1;
        end
      end else begin
        emit = 1'b1;
        unique case (r1_byte[7:6])
          qoi_pkg::TAG_INDEX: rgba_next = lookup;
          qoi_pkg::TAG_DIFF: begin
            cr = rgba[31:24] + {6'd0, r1_byte[5:4]} - 8'd2;
            cg = rgba[23:16] + {6'd0, r1_byte[3:2]} - 8'd2;
            cb = rgba[15:8] + {6'd0, r1_byte[1:0]} - 8'd2;
            rgba_next = {cr, cg, cb, rgba[7:0]};
          end
          default: count = r1_byte[5:0] + 6'd1;
        endcase
      end

      // End of image, or data ran out
      if (emit) begin
        done = over || (rem <= PW'(count));
        n_pix = over ? 6'd1 : (done ? rem[5:0] : count);
      end
      if (done) begin
        if (r1_eod) begin
          img_clear = 1'b1;
        end else begin
          discard_next = 1'b1;
        end
      end else if (r1_eod) begin
        err       = 1'b1;
        img_clear = 1'b1;
      end
    end
  end

  // Pixels left in the image
  assign over         = emitted >= target;
  assign rem          = target - emitted;
  assign emitted_next = emitted + PW'(n_pix);

  assign idx_waddr = qoi_pkg::index_hash(rgba_next);
  assign has_items = emit || err;
  assign r1_exec   = r1_valid && (!has_items || burst_free);
  assign burst_load = r1_exec && has_items;
  assign ram_we     = r1_exec && emit;

  assign desc.word   = (key_enable && !rgba_next[7]) ? key_value : {8'd0, rgba_next[31:8]};
  assign desc.pixels = n_pix;
  assign desc.done   = done;
  assign desc.err    = err;

  // State update, one byte per exec cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rgba    <= qoi_pkg::RGBA_RESET;
      op_pend <= 8'd0;
      needed  <= 3'd0;
      emitted <= '0;
      discard <= 1'b0;
    end else if (r1_exec) begin
      if (img_clear) begin
        rgba    <= qoi_pkg::RGBA_RESET;
        op_pend <= 8'd0;
        needed  <= 3'd0;
        emitted <= '0;
        discard <= 1'b0;
      end else begin
        rgba    <= rgba_next;
        op_pend <= op_pend_next;
        needed  <= needed_next;
        emitted <= emitted_next;
        discard <= discard_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1_exec) begin
      gathered <= gathered_next;
    end
  end

  // Index valid bits; a clear wins over the write on the same byte
  always_ff @(posedge clk) begin
    if (rst) begin
      idx_valid <= '0;
    end else if (r1_exec) begin
      if (img_clear) begin
        idx_valid <= '0;
      end else if (emit) begin
        idx_valid[idx_waddr] <= 1'b1;
      end
    end
  end

  qoi_burst u_burst (
    .clk  (clk),
    .rst  (rst),
    .load (burst_load),
    .desc (desc),
    .free (burst_free),
    .pixel(pixel)
  );

  `QOI_ASSERT_IMPL(a_discard_silent, clk, rst, r1_valid && discard, !burst_load)
  `QOI_ASSERT_NEXT(a_clear_index, clk, rst, r1_exec && img_clear, idx_valid == '0)
  `QOI_ASSERT_NEXT(a_hold_byte, clk, rst, r1_valid && !r1_exec, r1_valid && $stable(r1_byte))

endmodule

### rtl/qoi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qoi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/qoi_burst.sv
// Result stage: plays out the items of one byte, one per cycle while pixel.ready is high.
// Depends on qoi_pkg, qoi_if and the assertion macro header.
`include "qoi_image_decoder_defines.svh"

module qoi_burst (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  qoi_pkg::qoi_burst_t desc,
  output logic                free,
  qoi_pixel_if.source         pixel
);

  logic        busy;
  logic [31:0] word;
  logic [5:0]  left;
  logic        done;
  logic        err;
  logic        final_item;

  // Final item: last pixel with no error behind it, or the error itself
  assign final_item = (left == 6'd1 && !err) || (left == 6'd0);
  assign free       = !busy || (pixel.ready && final_item);

  assign pixel.valid        = busy;
  assign pixel.pixel_word   = (left != 6'd0) ? word : 32'd0;
  assign pixel.image_done   = done && (left == 6'd1);
  assign pixel.decode_error = (left == 6'd0);
  assign pixel.last         = final_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (busy && pixel.ready && final_item) begin
      busy <= 1'b0;
    end
  end

  // Descriptor payload; count down pixels as they are taken
  always_ff @(posedge clk) begin
    if (load) begin
      word <= desc.word;
      left <= desc.pixels;
      done <= desc.done;
      err  <= desc.err;
    end else if (busy && pixel.ready && left != 6'd0) begin
      left <= left - 6'd1;
    end
  end

  `QOI_ASSERT_IMPL(a_done_excl_err, clk, rst, busy, !(done && err))
  `QOI_ASSERT_IMPL(a_not_empty, clk, rst, busy, (left != 6'd0) || err)
  `QOI_ASSERT_NEXT(a_keep_busy, clk, rst, busy && pixel.ready && !final_item, busy)

endmodule
